>>> rtl/graph_dfs_preorder_unit_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the depth-first preorder unit
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef GRAPH_DFS_PREORDER_UNIT_ASSERT_SVH
`define GRAPH_DFS_PREORDER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GDFS_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define GDFS_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/gdfs_pkg.sv
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared widths, command codes and types of the depth-first preorder unit.
// ----------------------------------------------------------------------------
`default_nettype none

package gdfs_pkg;

   // Fixed field widths of the item ports.
   localparam int ID_W  = 6;
   localparam int CMD_W = 2;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_APPEND   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TRAVERSE = 2'd2;

   // Default sizing.
   localparam int DEF_MAX_NODES  = 64;
   localparam int DEF_MAX_DEGREE = 8;

   // One result item handed from the sequencer to the output register.
   typedef struct packed {
      logic            valid;
      logic            last;
      logic [ID_W-1:0] node;
      logic            overflow;
   } gdfs_push_type;

endpackage

`default_nettype wire

>>> rtl/gdfs_ram.sv
// ----------------------------------------------------------------------------
// gdfs_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. Read data holds while not read.
// ----------------------------------------------------------------------------
`default_nettype none

module gdfs_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> rtl/gdfs_seq.sv
// ----------------------------------------------------------------------------
// gdfs_seq
// Command sequencer and walk engine. Holds the neighbor lists, degrees,
// visited map and walk stack in RAMs and steps the depth-first walk with
// one access per RAM per cycle. The top of stack lives in registers.
// ----------------------------------------------------------------------------
`default_nettype none

module gdfs_seq #(
   parameter int MAX_NODES  = gdfs_pkg::DEF_MAX_NODES,
   parameter int MAX_DEGREE = gdfs_pkg::DEF_MAX_DEGREE
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [gdfs_pkg::CMD_W-1:0]    req_cmd,
   input  wire logic [gdfs_pkg::ID_W-1:0]     req_node_id,
   input  wire logic [gdfs_pkg::ID_W-1:0]     req_neighbor_id,
   input  wire logic                          out_free,
   output gdfs_pkg::gdfs_push_type            push
);

   import gdfs_pkg::*;

   localparam int NODE_W   = $clog2(MAX_NODES);
   localparam int DEG_W    = $clog2(MAX_DEGREE + 1);
   localparam int DEPTH_W  = $clog2(MAX_NODES + 1);
   localparam int NB_DEPTH = MAX_NODES * MAX_DEGREE;
   localparam int NB_AW    = $clog2(NB_DEPTH);
   localparam int STK_W    = NODE_W + 2 * DEG_W;

   // Sequencer states.
   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_APP     = 4'd1;
   localparam logic [3:0] ST_SWEEP   = 4'd2;
   localparam logic [3:0] ST_ROOT    = 4'd3;
   localparam logic [3:0] ST_ROOT_RD = 4'd4;
   localparam logic [3:0] ST_WALK    = 4'd5;
   localparam logic [3:0] ST_NB_RD   = 4'd6;
   localparam logic [3:0] ST_VIS_RD  = 4'd7;
   localparam logic [3:0] ST_POP_RD  = 4'd8;
   localparam logic [3:0] ST_FIN     = 4'd9;

   // Control registers.
   logic [3:0]           state_ff, state_in;
   logic [MAX_NODES-1:0] deg_valid_ff, deg_valid_in;
   logic                 ovf_ff, ovf_in;
   logic [DEPTH_W-1:0]   depth_ff, depth_in;

   // Datapath registers.
   logic [NODE_W-1:0]    node_ff, node_in;
   logic [NODE_W-1:0]    nbr_ff, nbr_in;
   logic [NODE_W-1:0]    sweep_ff, sweep_in;
   logic [NODE_W-1:0]    top_node_ff, top_node_in;
   logic [DEG_W-1:0]     top_next_ff, top_next_in;
   logic [DEG_W-1:0]     top_deg_ff, top_deg_in;
   logic [NODE_W-1:0]    pend_ff, pend_in;
   logic [NODE_W-1:0]    cand_ff, cand_in;
   logic                 deg_vld_rd_ff, deg_vld_rd_in;

   // RAM ports.
   logic                 nb_wr_en, nb_rd_en;
   logic [NB_AW-1:0]     nb_wr_addr, nb_rd_addr;
   logic [NODE_W-1:0]    nb_wr_data, nb_rd_data;
   logic                 deg_wr_en, deg_rd_en;
   logic [NODE_W-1:0]    deg_wr_addr, deg_rd_addr;
   logic [DEG_W-1:0]     deg_wr_data, deg_rd_data;
   logic                 vis_wr_en, vis_rd_en;
   logic [NODE_W-1:0]    vis_wr_addr, vis_rd_addr;
   logic                 vis_wr_data, vis_rd_data;
   logic                 stk_wr_en, stk_rd_en;
   logic [NODE_W-1:0]    stk_wr_addr, stk_rd_addr;
   logic [STK_W-1:0]     stk_wr_data, stk_rd_data;

   // Helper values.
   logic                 node_ok, nbr_ok;
   logic [DEG_W-1:0]     deg_cur;
   logic                 has_next, fresh;
   logic [DEPTH_W-1:0]   depth_m1, depth_m2;
   logic [NB_AW-1:0]     walk_addr, app_addr;

   assign node_ok  = ({1'b0, req_node_id} < (ID_W + 1)'(MAX_NODES));
   assign nbr_ok   = ({1'b0, req_neighbor_id} < (ID_W + 1)'(MAX_NODES));
   assign deg_cur  = deg_vld_rd_ff ? deg_rd_data : '0;
   assign has_next = (top_next_ff < top_deg_ff);
   assign fresh    = !vis_rd_data && (depth_ff < DEPTH_W'(MAX_NODES));
   assign depth_m1 = depth_ff - DEPTH_W'(1);
   assign depth_m2 = depth_ff - DEPTH_W'(2);

   // Flat neighbor-store addresses: row of the node, column of the index.
   assign walk_addr = NB_AW'(top_node_ff) * NB_AW'(MAX_DEGREE) + NB_AW'(top_next_ff);
   assign app_addr  = NB_AW'(node_ff) * NB_AW'(MAX_DEGREE) + NB_AW'(deg_cur);

   assign req_stall = (state_ff != ST_IDLE);

   // Next-state and memory access control.
   always_comb begin
      state_in     = state_ff;
      deg_valid_in = deg_valid_ff;
      ovf_in       = ovf_ff;
      depth_in     = depth_ff;
      node_in      = node_ff;
      nbr_in       = nbr_ff;
      sweep_in     = sweep_ff;
      top_node_in  = top_node_ff;
      top_next_in  = top_next_ff;
      top_deg_in   = top_deg_ff;
      pend_in      = pend_ff;
      cand_in      = cand_ff;

      nb_wr_en     = 1'b0;
      nb_wr_addr   = app_addr;
      nb_wr_data   = nbr_ff;
      nb_rd_en     = 1'b0;
      nb_rd_addr   = walk_addr;
      deg_wr_en    = 1'b0;
      deg_wr_addr  = node_ff;
      deg_wr_data  = deg_cur + DEG_W'(1);
      deg_rd_en    = 1'b0;
      deg_rd_addr  = node_ff;
      vis_wr_en    = 1'b0;
      vis_wr_addr  = sweep_ff;
      vis_wr_data  = 1'b0;
      vis_rd_en    = 1'b0;
      vis_rd_addr  = nb_rd_data;
      stk_wr_en    = 1'b0;
      stk_wr_addr  = depth_m1[NODE_W-1:0];
      stk_wr_data  = {top_node_ff, top_next_ff, top_deg_ff};
      stk_rd_en    = 1'b0;
      stk_rd_addr  = depth_m2[NODE_W-1:0];

      push.valid    = 1'b0;
      push.last     = 1'b0;
      push.node     = ID_W'(pend_ff);
      push.overflow = ovf_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_cmd)
                  CMD_CLEAR: begin
                     deg_valid_in = '0;
                  end
                  CMD_APPEND: begin
                     if (node_ok && nbr_ok) begin
                        node_in     = NODE_W'(req_node_id);
                        nbr_in      = NODE_W'(req_neighbor_id);
                        deg_rd_en   = 1'b1;
                        deg_rd_addr = NODE_W'(req_node_id);
                        state_in    = ST_APP;
                     end
                  end
                  CMD_TRAVERSE: begin
                     if (node_ok) begin
                        node_in  = NODE_W'(req_node_id);
                        sweep_in = '0;
                        state_in = ST_SWEEP;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         // Append: a full list drops the neighbor and flags it.
         ST_APP: begin
            if (deg_cur >= DEG_W'(MAX_DEGREE)) begin
               ovf_in = 1'b1;
            end else begin
               nb_wr_en              = 1'b1;
               deg_wr_en             = 1'b1;
               deg_valid_in[node_ff] = 1'b1;
            end
            state_in = ST_IDLE;
         end
         // Clear the visited map one entry per cycle.
         ST_SWEEP: begin
            vis_wr_en = 1'b1;
            if (sweep_ff == NODE_W'(MAX_NODES - 1)) begin
               state_in = ST_ROOT;
            end else begin
               sweep_in = sweep_ff + NODE_W'(1);
            end
         end
         ST_ROOT: begin
            vis_wr_en   = 1'b1;
            vis_wr_addr = node_ff;
            vis_wr_data = 1'b1;
            deg_rd_en   = 1'b1;
            state_in    = ST_ROOT_RD;
         end
         ST_ROOT_RD: begin
            top_node_in = node_ff;
            top_next_in = '0;
            top_deg_in  = deg_cur;
            depth_in    = DEPTH_W'(1);
            pend_in     = node_ff;
            state_in    = ST_WALK;
         end
         // Fetch the next neighbor of the top node, pop it, or finish at the root.
         ST_WALK: begin
            if (has_next) begin
               nb_rd_en    = 1'b1;
               top_next_in = top_next_ff + DEG_W'(1);
               state_in    = ST_NB_RD;
            end else if (depth_ff == DEPTH_W'(1)) begin
               state_in = ST_FIN;
            end else begin
               depth_in  = depth_m1;
               stk_rd_en = 1'b1;
               state_in  = ST_POP_RD;
            end
         end
         // Look up the candidate's visited bit and degree.
         ST_NB_RD: begin
            cand_in     = nb_rd_data;
            vis_rd_en   = 1'b1;
            deg_rd_en   = 1'b1;
            deg_rd_addr = nb_rd_data;
            state_in    = ST_VIS_RD;
         end
         // A new node is pushed and held as the old held node is emitted; otherwise try the next entry.
         ST_VIS_RD: begin
            if (fresh) begin
               if (out_free) begin
                  push.valid  = 1'b1;
                  vis_wr_en   = 1'b1;
                  vis_wr_addr = cand_ff;
                  vis_wr_data = 1'b1;
                  stk_wr_en   = 1'b1;
                  top_node_in = cand_ff;
                  top_next_in = '0;
                  top_deg_in  = deg_cur;
                  depth_in    = depth_ff + DEPTH_W'(1);
                  pend_in     = cand_ff;
                  state_in    = ST_WALK;
               end
            end else if (has_next) begin
               nb_rd_en    = 1'b1;
               top_next_in = top_next_ff + DEG_W'(1);
               state_in    = ST_NB_RD;
            end else begin
               state_in = ST_WALK;
            end
         end
         ST_POP_RD: begin
            {top_node_in, top_next_in, top_deg_in} = stk_rd_data;
            state_in = ST_WALK;
         end
         // The held node is the final one of the walk.
         ST_FIN: begin
            if (out_free) begin
               push.valid = 1'b1;
               push.last  = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Valid bit of the degree entry travels with the registered read.
   assign deg_vld_rd_in = deg_rd_en ? deg_valid_ff[deg_rd_addr] : deg_vld_rd_ff;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         deg_valid_ff <= '0;
         ovf_ff       <= 1'b0;
         depth_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         deg_valid_ff <= deg_valid_in;
         ovf_ff       <= ovf_in;
         depth_ff     <= depth_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      node_ff       <= node_in;
      nbr_ff        <= nbr_in;
      sweep_ff      <= sweep_in;
      top_node_ff   <= top_node_in;
      top_next_ff   <= top_next_in;
      top_deg_ff    <= top_deg_in;
      pend_ff       <= pend_in;
      cand_ff       <= cand_in;
      deg_vld_rd_ff <= deg_vld_rd_in;
   end

   // Neighbor lists, one row of MAX_DEGREE entries per node.
   gdfs_ram #(.WIDTH(NODE_W), .DEPTH(NB_DEPTH)) u_nb_ram (
      .clock   (clock),
      .wr_en   (nb_wr_en),
      .wr_addr (nb_wr_addr),
      .wr_data (nb_wr_data),
      .rd_en   (nb_rd_en),
      .rd_addr (nb_rd_addr),
      .rd_data (nb_rd_data)
   );

   // List lengths; entries without a valid bit read as zero.
   gdfs_ram #(.WIDTH(DEG_W), .DEPTH(MAX_NODES)) u_deg_ram (
      .clock   (clock),
      .wr_en   (deg_wr_en),
      .wr_addr (deg_wr_addr),
      .wr_data (deg_wr_data),
      .rd_en   (deg_rd_en),
      .rd_addr (deg_rd_addr),
      .rd_data (deg_rd_data)
   );

   // Visited map, swept clear at the start of every walk.
   gdfs_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis_ram (
      .clock   (clock),
      .wr_en   (vis_wr_en),
      .wr_addr (vis_wr_addr),
      .wr_data (vis_wr_data),
      .rd_en   (vis_rd_en),
      .rd_addr (vis_rd_addr),
      .rd_data (vis_rd_data)
   );

   // Walk stack below the top entry.
   gdfs_ram #(.WIDTH(STK_W), .DEPTH(MAX_NODES)) u_stk_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_en   (stk_rd_en),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

endmodule

`default_nettype wire

>>> rtl/graph_dfs_preorder_unit.sv
// ----------------------------------------------------------------------------
// graph_dfs_preorder_unit
// Directed graph store with depth-first preorder traversal.
//
//   Channel  Ports                                        Direction
//   req      req_valid/req_stall, cmd, node_id,           in
//            neighbor_id
//   rsp      rsp_valid/rsp_stall, visited_node, last,     out
//            list_overflow
//
// Clear is applied on acceptance; append reads the list length, then writes.
// A traverse first sweeps the visited map, then sets up the root, scans each
// neighbor entry and pops each finished node; one access per RAM port per
// cycle and the registered RAM reads set the length of each step.
// Reset is synchronous and empties all lists and clears the overflow flag.
// A stalled result holds the walk; the next item is taken once the final
// node sits in the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module graph_dfs_preorder_unit #(
   parameter int MAX_NODES  = gdfs_pkg::DEF_MAX_NODES,
   parameter int MAX_DEGREE = gdfs_pkg::DEF_MAX_DEGREE
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_stall,
   input  wire logic [gdfs_pkg::CMD_W-1:0] req_cmd,
   input  wire logic [gdfs_pkg::ID_W-1:0]  req_node_id,
   input  wire logic [gdfs_pkg::ID_W-1:0]  req_neighbor_id,
   output logic                            rsp_valid,
   input  wire logic                       rsp_stall,
   output logic [gdfs_pkg::ID_W-1:0]       rsp_visited_node,
   output logic                            rsp_last,
   output logic                            rsp_list_overflow
);

   import gdfs_pkg::*;

   gdfs_push_type     push;
   logic              out_free;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ID_W-1:0]   node_ff;
   logic              last_ff;
   logic              ovf_ff;

   gdfs_seq #(.MAX_NODES(MAX_NODES), .MAX_DEGREE(MAX_DEGREE)) u_seq (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_node_id     (req_node_id),
      .req_neighbor_id (req_neighbor_id),
      .out_free        (out_free),
      .push            (push)
   );

   // Output register: free when empty or being taken this cycle.
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = push.valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload loads with each new item.
   always_ff @(posedge clock) begin
      if (push.valid) begin
         node_ff <= push.node;
         last_ff <= push.last;
         ovf_ff  <= push.overflow;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_visited_node  = node_ff;
   assign rsp_last          = last_ff;
   assign rsp_list_overflow = ovf_ff;

endmodule

`default_nettype wire

>>> rtl/graph_dfs_preorder_unit_chk.sv
// ----------------------------------------------------------------------------
// graph_dfs_preorder_unit_chk
// Port-level checker for the depth-first preorder unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none
`include "graph_dfs_preorder_unit_assert.svh"

module graph_dfs_preorder_unit_chk #(
   parameter int MAX_NODES = gdfs_pkg::DEF_MAX_NODES
) (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       req_valid,
   input wire logic                       req_stall,
   input wire logic [gdfs_pkg::CMD_W-1:0] req_cmd,
   input wire logic [gdfs_pkg::ID_W-1:0]  req_node_id,
   input wire logic                       rsp_valid,
   input wire logic                       rsp_stall,
   input wire logic [gdfs_pkg::ID_W-1:0]  rsp_visited_node,
   input wire logic                       rsp_last,
   input wire logic                       rsp_list_overflow
);

   import gdfs_pkg::*;

   logic       trav_go, trav_end;
   logic [1:0] open_ff, open_in;
   logic       seen_ovf_ff, seen_ovf_in;
   logic       node_ok;

   // Traversals that produce results and have not delivered their final item.
   assign trav_go  = req_valid && !req_stall && (req_cmd == CMD_TRAVERSE) &&
                     ({1'b0, req_node_id} < (ID_W + 1)'(MAX_NODES));
   assign trav_end = rsp_valid && !rsp_stall && rsp_last;
   assign open_in  = open_ff + 2'(trav_go) - 2'(trav_end);

   // The overflow flag, once shown, is sticky until reset.
   assign seen_ovf_in = seen_ovf_ff || (rsp_valid && rsp_list_overflow);

   // A visited node always names an existing node.
   assign node_ok = ({1'b0, rsp_visited_node} < (ID_W + 1)'(MAX_NODES));

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff     <= '0;
         seen_ovf_ff <= 1'b0;
      end else begin
         open_ff     <= open_in;
         seen_ovf_ff <= seen_ovf_in;
      end
   end

   `GDFS_ASSERT_NEXT(a_rsp_hold, clock, reset, !reset && rsp_valid && rsp_stall, rsp_valid && $stable(rsp_visited_node) && $stable(rsp_last), "stalled result item changed")
   `GDFS_ASSERT_NOW(a_rsp_in_walk, clock, reset, rsp_valid, open_ff != 2'd0, "result item outside a traversal")
   `GDFS_ASSERT_NOW(a_ovf_sticky, clock, reset, rsp_valid && seen_ovf_ff, rsp_list_overflow, "overflow flag dropped")
   `GDFS_ASSERT_NOW(a_node_range, clock, reset, rsp_valid, node_ok, "visited node out of range")

endmodule

bind graph_dfs_preorder_unit graph_dfs_preorder_unit_chk #(.MAX_NODES(MAX_NODES)) u_chk (.*);

`default_nettype wire

>>> bench/graph_dfs_preorder_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Depth-first preorder checker
// Watches the request and result channels of graph_dfs_preorder_unit. It
// keeps its own copy of the neighbor lists and the overflow flag, and works
// out the preorder walk for every traverse item it sees accepted. Each
// accepted result item is compared field by field with the oldest expected
// visit.
// ----------------------------------------------------------------------------

module graph_dfs_preorder_checker
   import gdfs_pkg::*;
#(
   parameter int NODES  = DEF_MAX_NODES,
   parameter int DEGREE = DEF_MAX_DEGREE
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  logic [CMD_W-1:0] req_cmd,
   input  logic [ID_W-1:0]  req_node_id,
   input  logic [ID_W-1:0]  req_neighbor_id,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  logic [ID_W-1:0]  rsp_visited_node,
   input  logic             rsp_last,
   input  logic             rsp_list_overflow,
   output int               error_count,
   output int               pending_visits
);

   typedef struct packed {
      logic [ID_W-1:0] node;
      logic            last;
      logic            overflow;
   } visit_type;

   // Shadow copy of the graph store and the sticky overflow flag.
   logic [ID_W-1:0]               adjacency [NODES][DEGREE];
   logic [$clog2(DEGREE+1)-1:0]   degree [NODES];
   logic                          list_full;

   // Visits still to come, oldest first.
   visit_type visit_q [$];

   // The newest visit is held back one step so that the final one of a walk
   // can be marked as last before it is queued.
   visit_type held;
   bit        have_held;

   function automatic void emit_visit(input logic [ID_W-1:0] node);
      if (have_held) visit_q = {visit_q, held};
      held      = '{node: node, last: 1'b0, overflow: list_full};
      have_held = 1'b1;
   endfunction

   always @(posedge clock) begin
      visit_type       want;
      bit              seen [NODES];
      logic [ID_W-1:0] path_node [NODES];
      int              path_next [NODES];
      int              depth;
      logic [ID_W-1:0] here;
      logic [ID_W-1:0] nxt;

      if (reset) begin
         foreach (degree[i]) degree[i] = '0;
         list_full = 1'b0;
         visit_q.delete();
      end else begin
         // Compare an accepted result item with the oldest expected visit.
         if (rsp_valid && !rsp_stall) begin
            if (visit_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, got node %0d last %0b ovf %0b",
                        $time, rsp_visited_node, rsp_last, rsp_list_overflow);
               error_count++;
            end else begin
               want = visit_q.pop_front();
               if (rsp_visited_node !== want.node) begin
                  $display("%0t: visited_node mismatch, expected %0d, got %0d",
                           $time, want.node, rsp_visited_node);
                  error_count++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t: last mismatch, expected %0b, got %0b",
                           $time, want.last, rsp_last);
                  error_count++;
               end
               if (rsp_list_overflow !== want.overflow) begin
                  $display("%0t: list_overflow mismatch, expected %0b, got %0b",
                           $time, want.overflow, rsp_list_overflow);
                  error_count++;
               end
            end
         end

         // Apply an accepted request item to the shadow graph.
         if (req_valid && !req_stall) begin
            case (req_cmd)
               CMD_CLEAR: begin
                  // The overflow flag survives a clear.
                  foreach (degree[i]) degree[i] = '0;
               end
               CMD_APPEND: begin
                  if (degree[req_node_id] >= DEGREE) begin
                     list_full = 1'b1;
                  end else begin
                     adjacency[req_node_id][degree[req_node_id]] = req_neighbor_id;
                     degree[req_node_id]++;
                  end
               end
               CMD_TRAVERSE: begin
                  // Walk with an explicit stack, neighbors in append order.
                  foreach (seen[i]) seen[i] = 1'b0;
                  have_held          = 1'b0;
                  seen[req_node_id]  = 1'b1;
                  emit_visit(req_node_id);
                  path_node[0] = req_node_id;
                  path_next[0] = 0;
                  depth        = 1;
                  while (depth > 0) begin
                     here = path_node[depth-1];
                     if (path_next[depth-1] < degree[here]) begin
                        nxt = adjacency[here][path_next[depth-1]];
                        path_next[depth-1]++;
                        if (!seen[nxt] && depth < NODES) begin
                           seen[nxt] = 1'b1;
                           emit_visit(nxt);
                           path_node[depth] = nxt;
                           path_next[depth] = 0;
                           depth++;
                        end
                     end else begin
                        depth--;
                     end
                  end
                  held.last = 1'b1;
                  visit_q   = {visit_q, held};
               end
               default: begin
                  // The unused command code is ignored.
               end
            endcase
         end
      end
      pending_visits = visit_q.size();
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for graph_dfs_preorder_unit
// Builds graphs with clear and append items and walks them with traverse
// items: a directed opening, then random graphs of several densities, one
// full-length chain and some noise. Both channels idle at random; the result
// side holds off once for a long stretch. Checking is done by the checker.
// ----------------------------------------------------------------------------

module tb;
   import gdfs_pkg::*;

   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
   localparam int NODES       = DEF_MAX_NODES;
   localparam int TOTAL_ITEMS = 260;
   localparam int LONG_HOLD   = 300;
   localparam int TAIL_CYCLES = 200;
   localparam int CYCLE_LIMIT = 3_000_000;

   logic             clock;
   logic             reset           = 1'b1;
   logic             req_valid       = 1'b0;
   logic             req_stall;
   logic [CMD_W-1:0] req_cmd         = CMD_CLEAR;
   logic [ID_W-1:0]  req_node_id     = '0;
   logic [ID_W-1:0]  req_neighbor_id = '0;
   logic             rsp_valid;
   logic             rsp_stall       = 1'b0;
   logic [ID_W-1:0]  rsp_visited_node;
   logic             rsp_last;
   logic             rsp_list_overflow;

   int error_count;
   int pending_visits;
   int sent_items    = 0;
   bit quiet         = 1'b0;
   bit long_hold_req = 1'b0;

   graph_dfs_preorder_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_node_id       (req_node_id),
      .req_neighbor_id   (req_neighbor_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_visited_node  (rsp_visited_node),
      .rsp_last          (rsp_last),
      .rsp_list_overflow (rsp_list_overflow)
   );

   graph_dfs_preorder_checker i_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_node_id       (req_node_id),
      .req_neighbor_id   (req_neighbor_id),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_visited_node  (rsp_visited_node),
      .rsp_last          (rsp_last),
      .rsp_list_overflow (rsp_list_overflow),
      .error_count       (error_count),
      .pending_visits    (pending_visits)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog on the total run length.
   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Test completed with failures");
      $finish;
   end

   // Result side: a random stall before each item, plus one long hold-off.
   initial begin : result_sink
      int stall_cycles;
      @(posedge clock);
      forever begin
         stall_cycles = quiet ? 0 : $urandom_range(0, 5);
         if (long_hold_req) begin
            stall_cycles += LONG_HOLD;
            long_hold_req = 1'b0;
         end
         if (stall_cycles > 0) begin
            rsp_stall <= 1'b1;
            repeat (stall_cycles) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
      end
   end

   // Offer one item after a random gap and wait until it is taken.
   task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] node,
                            input logic [ID_W-1:0] nb);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= cmd;
      req_node_id     <= node;
      req_neighbor_id <= nb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_items++;
   endtask

   // Stop offering items until every expected visit has come out.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_visits != 0) @(posedge clock);
   endtask

   // Node id from a pool of span ids, scattered over the id space by mask.
   function automatic logic [ID_W-1:0] pick_id(input int span, input logic [ID_W-1:0] mask);
      return ID_W'($urandom_range(0, span - 1)) ^ mask;
   endfunction

   initial begin : stimulus
      int              perm [NODES];
      int              i;
      int              j;
      int              swap;
      int              span;
      int              edges;
      int              trips;
      int              episode;
      logic [ID_W-1:0] mask;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // An empty graph yields only the start node.
      send_item(CMD_TRAVERSE, 6'd0, 6'd0);

      // Small graph with a self loop, a duplicate edge and a back edge.
      send_item(CMD_APPEND, 6'd0, 6'd63);
      send_item(CMD_APPEND, 6'd0, 6'd0);
      send_item(CMD_APPEND, 6'd0, 6'd63);
      send_item(CMD_APPEND, 6'd63, 6'd21);
      send_item(CMD_APPEND, 6'd21, 6'd0);
      send_item(CMD_APPEND, 6'd63, 6'd42);
      send_item(CMD_TRAVERSE, 6'd0, 6'd63);
      send_item(CMD_TRAVERSE, 6'd63, 6'd0);

      // The unused command code must leave everything as it was.
      send_item(CMD_UNUSED, 6'd63, 6'd63);

      // Overfill one list: the ninth neighbor is dropped and the flag sets.
      for (i = 1; i <= 9; i++) send_item(CMD_APPEND, 6'd42, ID_W'(i));
      send_item(CMD_TRAVERSE, 6'd42, 6'd0);

      // Clear empties the lists but keeps the overflow flag.
      send_item(CMD_CLEAR, 6'd42, 6'd42);
      send_item(CMD_TRAVERSE, 6'd42, 6'd0);
      send_item(CMD_APPEND, 6'd42, 6'd9);
      send_item(CMD_TRAVERSE, 6'd42, 6'd0);

      // Random graphs, one long chain, and noise in between.
      episode = 0;
      while (sent_items < TOTAL_ITEMS) begin
         quiet = (episode % 4 == 3);
         if (episode == 1) begin
            // A chain through all nodes in random order drives the stack to
            // full depth; the result side holds off meanwhile.
            foreach (perm[k]) perm[k] = k;
            for (i = NODES - 1; i > 0; i--) begin
               j       = $urandom_range(0, i);
               swap    = perm[i];
               perm[i] = perm[j];
               perm[j] = swap;
            end
            send_item(CMD_CLEAR, pick_id(NODES, '0), pick_id(NODES, '0));
            for (i = 0; i < NODES - 1; i++)
               send_item(CMD_APPEND, ID_W'(perm[i]), ID_W'(perm[i+1]));
            long_hold_req = 1'b1;
            send_item(CMD_TRAVERSE, ID_W'(perm[0]), pick_id(NODES, '0));
            send_item(CMD_TRAVERSE, ID_W'(perm[40]), pick_id(NODES, '0));
            send_item(CMD_APPEND, ID_W'(perm[NODES-1]), ID_W'(perm[0]));
            send_item(CMD_TRAVERSE, ID_W'(perm[NODES-1]), pick_id(NODES, '0));
         end else begin
            // Dense graphs on a few nodes, or sparse ones over all ids.
            case ($urandom_range(0, 2))
               0:       span = 4;
               1:       span = 16;
               default: span = NODES;
            endcase
            mask = pick_id(NODES, '0);
            // Now and then the old lists are kept and keep growing.
            if ($urandom_range(0, 3) != 0)
               send_item(CMD_CLEAR, pick_id(NODES, '0), pick_id(NODES, '0));
            edges = $urandom_range(1, 40);
            for (i = 0; i < edges; i++) begin
               if ($urandom_range(0, 15) == 0)
                  send_item(CMD_UNUSED, pick_id(NODES, '0), pick_id(NODES, '0));
               else if ($urandom_range(0, 15) == 0)
                  send_item(CMD_TRAVERSE, pick_id(NODES, '0), pick_id(NODES, '0));
               else
                  send_item(CMD_APPEND, pick_id(span, mask), pick_id(span, mask));
            end
            trips = $urandom_range(1, 3);
            for (i = 0; i < trips; i++)
               send_item(CMD_TRAVERSE, pick_id(span, mask), pick_id(NODES, '0));
         end
         // Once mid-run the sender waits for the block to drain completely.
         if (episode == 4) wait_drained();
         episode++;
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_visits == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

>>> graph_dfs_preorder_unit.f
+incdir+rtl
rtl/gdfs_pkg.sv
rtl/gdfs_ram.sv
rtl/gdfs_seq.sv
rtl/graph_dfs_preorder_unit.sv
rtl/graph_dfs_preorder_unit_chk.sv
bench/graph_dfs_preorder_checker.sv
bench/tb.sv
